/* rtl/assert_macros.svh */
// Assertion macros shared by the list RTL.
// No dependencies; the synthesis build sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SL_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: always");
`define SL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`else
`define SL_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/sl_pkg.sv */
// Types, constants and helpers for the sorted list with cursor.
// No dependencies.
package sl_pkg;

    localparam int CAPACITY     = 16;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 64;
    localparam int FUNC_BITS    = 3;
    localparam int OUT_POS_W    = 5;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int POS_W        = $clog2(CAPACITY + 2);
    localparam int S_FIELDS_W   = FUNC_BITS + KEY_BITS + PAYLOAD_BITS;
    localparam int S_TDATA_W    = (S_FIELDS_W + 7) / 8 * 8;
    localparam int M_FIELDS_W   = 2 * OUT_POS_W + KEY_BITS + PAYLOAD_BITS + 6;
    localparam int M_TDATA_W    = (M_FIELDS_W + 7) / 8 * 8;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_NEW,
        SEL_LEFT,
        SEL_RIGHT
    } cell_sel_t;

    typedef enum logic [FUNC_BITS-1:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_FIRST    = 3'd2,
        OP_LAST     = 3'd3,
        OP_ADVANCE  = 3'd4,
        OP_RETREAT  = 3'd5,
        OP_READ     = 3'd6,
        OP_READ_ALT = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_GUARD   = 2'd2,
        STAT_BLOCKED = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] del_idx;
    } chain_ctrl_t;

    function automatic logic [OUT_POS_W-1:0] to_out_pos(input logic [POS_W-1:0] pos);
        logic [31:0] wide;
        wide = 32'(pos);
        return wide[OUT_POS_W-1:0];
    endfunction

endpackage

/* rtl/sorted_list_with_cursor.sv */
// Sorted list with cursor, top level. Depends on sl_pkg, sl_chain, assert_macros.svh.
// An accepted input word is registered, then applied in ST_APPLY, which loads the
// result word into the output register; no new word is accepted until then. The apply
// step of the cell row waits while the output register still holds an untaken word.
// Reset: entry count and cursor clear to zero (head guard); cell storage is
// not cleared and holds nothing readable until written.
`include "assert_macros.svh"

module sorted_list_with_cursor
    import sl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // func[2:0], key[18:3], payload[82:19], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // cursor_position[4:0], item_valid[5], cur_key[21:6], cur_payload[85:22],
    // entry_count[90:86], is_empty[91], at_first[92], at_last[93], status[95:94]
    output logic [M_TDATA_W-1:0] m_tdata
);

    state_t                state_reg, state_next;
    logic [POS_W-1:0]      count_reg, count_next;
    logic [POS_W-1:0]      cursor_reg, cursor_next;
    op_t                   func_reg;
    entry_t                new_reg;
    logic [CAPACITY-1:0]   marks_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic                  accept, out_free, commit;
    logic                  do_ins, do_del, use_new, item_valid;
    status_t               status;
    logic [POS_W-1:0]      cursor_dec, cur_dec;
    logic [IDX_W-1:0]      rd_idx;
    chain_ctrl_t           ctrl;
    entry_t                in_entry, rd_entry, out_entry;
    logic [CAPACITY-1:0]   marks_now;
    logic [POS_W-1:0]      ins_pos;

    assign in_entry.key     = s_tdata[FUNC_BITS +: KEY_BITS];
    assign in_entry.payload = s_tdata[FUNC_BITS + KEY_BITS +: PAYLOAD_BITS];

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_APPLY) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_APPLY;
            ST_APPLY: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
    end

    // operation decode
    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        status      = STAT_OK;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        use_new     = 1'b0;
        unique case (func_reg)
            OP_INSERT:
            begin
                if (count_reg == POS_W'(CAPACITY))
                    status = STAT_FULL;
                else
                begin
                    do_ins      = 1'b1;
                    use_new     = 1'b1;
                    count_next  = count_reg + 1'b1;
                    cursor_next = ins_pos + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (cursor_reg != '0 && cursor_reg <= count_reg)
                begin
                    do_del     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                    status = STAT_GUARD;
            end
            OP_FIRST:   cursor_next = POS_W'(1);
            OP_LAST:    cursor_next = count_reg;
            OP_ADVANCE:
            begin
                if (cursor_reg < count_reg)
                    cursor_next = cursor_reg + 1'b1;
                else
                    status = STAT_BLOCKED;
            end
            OP_RETREAT:
            begin
                if (cursor_reg >= POS_W'(2))
                    cursor_next = cursor_reg - 1'b1;
                else
                    status = STAT_BLOCKED;
            end
            OP_READ, OP_READ_ALT: ;
            default: ;
        endcase
        cursor_dec = cursor_next - 1'b1;
        cur_dec    = cursor_reg - 1'b1;
        // after a delete the entry under the cursor is the old right neighbor
        rd_idx     = do_del ? cursor_reg[IDX_W-1:0] : cursor_dec[IDX_W-1:0];
        item_valid = (cursor_next != '0) && (cursor_next <= count_next);
        out_entry  = use_new ? new_reg : rd_entry;
    end

    assign ctrl.ins     = do_ins && commit;
    assign ctrl.del     = do_del && commit;
    assign ctrl.del_idx = cur_dec[IDX_W-1:0];

    sl_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_entry (new_reg),
        .cmp_key   (in_entry.key),
        .count     (count_reg),
        .marks     (marks_reg),
        .rd_idx    (rd_idx),
        .marks_now (marks_now),
        .ins_pos   (ins_pos),
        .rd_entry  (rd_entry)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready)
            m_tvalid_next = 1'b0;
        if (commit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({
                status,
                cursor_next == count_next,
                cursor_next == POS_W'(1),
                count_next == '0,
                to_out_pos(count_next),
                item_valid ? out_entry.payload : {PAYLOAD_BITS{1'b0}},
                item_valid ? out_entry.key : {KEY_BITS{1'b0}},
                item_valid,
                to_out_pos(cursor_next)
            });
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (commit)
            begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (accept)
        begin
            func_reg  <= op_t'(s_tdata[FUNC_BITS-1:0]);
            new_reg   <= in_entry;
            marks_reg <= marks_now;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SL_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= POS_W'(CAPACITY))
    `SL_ASSERT_ALWAYS(a_cursor_bound, clk, rst_n, cursor_reg <= count_reg + 1'b1)
    `SL_ASSERT_IMPLY(a_load_after_apply, clk, rst_n, $rose(m_tvalid_reg), $past(state_reg) == ST_APPLY)
    `SL_ASSERT_IMPLY(a_no_ins_del, clk, rst_n, ctrl.ins, !ctrl.del)

endmodule

/* rtl/sl_cell.sv */
// One list cell: holds an entry, loads new/left/right data, compares its key.
// Depends on sl_pkg.
module sl_cell
    import sl_pkg::*;
(
    input  logic                clk,
    input  cell_sel_t           sel,
    input  entry_t              new_entry,
    input  entry_t              left_entry,
    input  entry_t              right_entry,
    input  logic [KEY_BITS-1:0] cmp_key,
    output entry_t              entry,
    output logic                gt
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        unique case (sel)
            SEL_HOLD:  entry_next = entry_reg;
            SEL_NEW:   entry_next = new_entry;
            SEL_LEFT:  entry_next = left_entry;
            SEL_RIGHT: entry_next = right_entry;
            default:   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign gt    = entry_reg.key > cmp_key;

endmodule

/* rtl/sl_chain.sv */
// Row of list cells with per-cell shift control, insert position and read port.
// Depends on sl_pkg and sl_cell.
module sl_chain
    import sl_pkg::*;
(
    input  logic                clk,
    input  chain_ctrl_t         ctrl,
    input  entry_t              new_entry,
    input  logic [KEY_BITS-1:0] cmp_key,
    input  logic [POS_W-1:0]    count,
    input  logic [CAPACITY-1:0] marks,
    input  logic [IDX_W-1:0]    rd_idx,
    output logic [CAPACITY-1:0] marks_now,
    output logic [POS_W-1:0]    ins_pos,
    output entry_t              rd_entry
);

    entry_t          cell_q   [CAPACITY];
    entry_t          left_in  [CAPACITY];
    entry_t          right_in [CAPACITY];
    cell_sel_t       sel      [CAPACITY];
    logic [CAPACITY-1:0] gt;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign left_in[g] = new_entry;
            end
            else
            begin : g_mid
                assign left_in[g] = cell_q[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_in[g] = cell_q[g];
            end
            else
            begin : g_body
                assign right_in[g] = cell_q[g+1];
            end

            sl_cell u_cell (
                .clk         (clk),
                .sel         (sel[g]),
                .new_entry   (new_entry),
                .left_entry  (left_in[g]),
                .right_entry (right_in[g]),
                .cmp_key     (cmp_key),
                .entry       (cell_q[g]),
                .gt          (gt[g])
            );
        end
    endgenerate

    // mark: cell sits at or after the insert point (thermometer)
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            marks_now[i] = (POS_W'(i) >= count) || gt[i];
        end
    end

    always_comb
    begin
        logic prev;
        ins_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            prev = (i == 0) ? 1'b0 : marks[i-1];
            sel[i] = SEL_HOLD;
            if (ctrl.ins)
            begin
                if (marks[i] && prev)
                    sel[i] = SEL_LEFT;
                else if (marks[i])
                    sel[i] = SEL_NEW;
            end
            else if (ctrl.del && (IDX_W'(i) >= ctrl.del_idx))
            begin
                sel[i] = SEL_RIGHT;
            end
            if (marks[i] && !prev)
                ins_pos = ins_pos | POS_W'(i);
        end
    end

    assign rd_entry = cell_q[rd_idx];

endmodule
